// File: src/ssf_pkg.sv
// Shared types and constants for the segment size filter.
package ssf_pkg;

	localparam int LBL_W   = 16;
	localparam int SIZE_W  = 11;
	localparam int POS_W   = 10;
	localparam int IDX_W   = 30;
	localparam int TOTAL_W = 31;
	localparam int LIMIT_W = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [SIZE_W-1:0] MAX_SIZE = 11'd1024;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_FILTER = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_SIZE_X     = 2'd0,
		REG_SIZE_Y     = 2'd1,
		REG_SIZE_Z     = 2'd2,
		REG_SIZE_LIMIT = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic exec_count;
		logic exec_filter;
		logic exec_clear;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    clr_done;
		logic    out_busy;
	} status_t;

endpackage

// File: src/ssf_ram.sv
// Generic single write port RAM with one registered read port.
module ssf_ram import ssf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/ssf_regs.sv
// Configuration registers, APB access and derived volume geometry.
module ssf_regs import ssf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic [POS_W-1:0]   last_x,
	output logic [POS_W-1:0]   last_y,
	output logic [POS_W-1:0]   last_z,
	output logic [TOTAL_W-1:0] total,
	output logic [LIMIT_W-1:0] size_limit
);

	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [LIMIT_W-1:0] size_limit_q;
	logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
	logic [21:0]        xy_full;
	logic [20:0]        xy_q;
	logic [31:0]        total_full;
	logic [TOTAL_W-1:0] total_q;
	logic               wr_en;
	reg_index_t         idx;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > MAX_SIZE) begin
			r = MAX_SIZE;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign idx   = reg_index_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q     <= SIZE_W'(1);
			size_y_q     <= SIZE_W'(1);
			size_z_q     <= SIZE_W'(1);
			size_limit_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SIZE_X:     size_x_q     <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y:     size_y_q     <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z:     size_z_q     <= pwdata[SIZE_W-1:0];
				REG_SIZE_LIMIT: size_limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SIZE_X:     prdata = {21'b0, size_x_q};
			REG_SIZE_Y:     prdata = {21'b0, size_y_q};
			REG_SIZE_Z:     prdata = {21'b0, size_z_q};
			REG_SIZE_LIMIT: prdata = size_limit_q;
			default:        prdata = '0;
		endcase
	end

	assign eff_x = eff_size(size_x_q);
	assign eff_y = eff_size(size_y_q);
	assign eff_z = eff_size(size_z_q);

	assign last_x = POS_W'(eff_x - SIZE_W'(1));
	assign last_y = POS_W'(eff_y - SIZE_W'(1));
	assign last_z = POS_W'(eff_z - SIZE_W'(1));

	// The voxel total is rebuilt every cycle in two multiply stages.
	assign xy_full    = {11'b0, eff_x} * {11'b0, eff_y};
	assign total_full = {11'b0, xy_q} * {21'b0, eff_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_q    <= 21'd1;
			total_q <= TOTAL_W'(1);
		end else begin
			xy_q    <= xy_full[20:0];
			total_q <= total_full[TOTAL_W-1:0];
		end
	end

	assign total      = total_q;
	assign size_limit = size_limit_q;

endmodule

// File: src/ssf_ctrl.sv
// Controller state machine sequencing clears and per-item read-modify-write.
module ssf_ctrl import ssf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (status.op)
					OP_CLEAR:  state_d = ST_CLEAR;
					OP_FILTER: state_d = status.out_busy ? ST_EXEC : ST_IDLE;
					default:   state_d = ST_IDLE;
				endcase
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_EXEC: begin
				cmd.exec_count  = (status.op == OP_COUNT);
				cmd.exec_filter = (status.op == OP_FILTER) && !status.out_busy;
				cmd.exec_clear  = (status.op == OP_CLEAR);
			end
			default: ;
		endcase
	end

endmodule

// File: src/ssf_dp.sv
// Datapath: label store, position counters, filter decision and output register.
module ssf_dp import ssf_pkg::*; #(
	parameter int LABEL_COUNT = 65536,
	parameter int COUNT_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [1:0]         opcode,
	input  logic [LBL_W-1:0]   voxel_label,
	input  logic [POS_W-1:0]   last_x,
	input  logic [POS_W-1:0]   last_y,
	input  logic [POS_W-1:0]   last_z,
	input  logic [TOTAL_W-1:0] total,
	input  logic [LIMIT_W-1:0] size_limit,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [LBL_W-1:0]   filtered_label,
	output logic               last_voxel
);

	localparam int MEM_DEPTH = (LABEL_COUNT < 65536) ? LABEL_COUNT : 65536;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int WORD_W    = COUNT_BITS + 1;
	localparam int CMP_W     = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [AW-1:0]         CLR_LAST  = AW'(MEM_DEPTH - 1);

	opcode_t            op_q;
	logic [LBL_W-1:0]   label_q;
	logic [POS_W-1:0]   pos_x_q, pos_y_q, pos_z_q;
	logic [IDX_W-1:0]   fidx_q;
	logic [AW-1:0]      clr_addr_q;
	logic [WORD_W-1:0]  upd_s2;
	logic               erase_s2;
	logic               out_valid_q;
	logic [LBL_W-1:0]   out_label_q;
	logic               out_last_q;

	logic [WORD_W-1:0]     rdata;
	logic [COUNT_BITS-1:0] cnt;
	logic                  border;
	logic                  in_range;
	logic                  on_edge;
	logic [COUNT_BITS-1:0] cnt_next;
	logic                  below_limit;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [WORD_W-1:0]     wdata;
	logic [TOTAL_W-1:0]    fidx_inc;
	logic                  is_last;

	ssf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.accept),
		.raddr (voxel_label[AW-1:0]),
		.rdata (rdata)
	);

	assign we    = cmd.clr_step || (cmd.exec_count && in_range);
	assign waddr = cmd.clr_step ? clr_addr_q : label_q[AW-1:0];
	assign wdata = cmd.clr_step ? '0 : upd_s2;

	assign cnt      = rdata[COUNT_BITS-1:0];
	assign border   = rdata[COUNT_BITS];
	assign in_range = ({16'b0, label_q} < 32'(LABEL_COUNT));
	assign on_edge  = (pos_x_q == '0) || (pos_x_q == last_x) ||
	                  (pos_y_q == '0) || (pos_y_q == last_y) ||
	                  (pos_z_q == '0) || (pos_z_q == last_z);
	assign cnt_next    = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
	assign below_limit = CMP_W'(cnt) < CMP_W'(size_limit);

	assign fidx_inc = {1'b0, fidx_q} + TOTAL_W'(1);
	assign is_last  = (fidx_inc >= total);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode_t'(opcode);
			label_q <= voxel_label;
		end
		if (cmd.load) begin
			upd_s2   <= {border || on_edge, cnt_next};
			erase_s2 <= in_range && below_limit && !border;
		end
		if (cmd.exec_filter) begin
			out_label_q <= erase_s2 ? '0 : label_q;
			out_last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			fidx_q      <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec_clear) begin
				pos_x_q    <= '0;
				pos_y_q    <= '0;
				pos_z_q    <= '0;
				fidx_q     <= '0;
				clr_addr_q <= '0;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.exec_count) begin
				if (pos_x_q >= last_x) begin
					pos_x_q <= '0;
					if (pos_y_q >= last_y) begin
						pos_y_q <= '0;
						pos_z_q <= (pos_z_q >= last_z) ? '0 : pos_z_q + POS_W'(1);
					end else begin
						pos_y_q <= pos_y_q + POS_W'(1);
					end
				end else begin
					pos_x_q <= pos_x_q + POS_W'(1);
				end
			end
			if (cmd.exec_filter) begin
				fidx_q <= is_last ? '0 : fidx_inc[IDX_W-1:0];
			end
			if (cmd.exec_filter) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.op       = op_q;
	assign status.clr_done = (clr_addr_q == CLR_LAST);
	assign status.out_busy = out_valid_q && !result_ready;

	assign result_valid   = out_valid_q;
	assign filtered_label = out_label_q;
	assign last_voxel     = out_last_q;

endmodule

// File: src/segment_size_filter.sv
// Top level of the segment size filter: registers, controller and datapath.
// Usage: voxels of a 3D label volume stream in on the item channel
// (item_valid/item_ready, fields opcode and voxel_label) in x-fastest order.
// Opcode 0 counts a voxel, opcode 1 filters a voxel, opcode 2 clears the
// label store and all position counters; opcode 3 is ignored.
// Only filter voxels produce a transfer on the result channel
// (result_valid/result_ready, fields filtered_label and last_voxel).
// Every item passes through three steps: accept it and read the label store,
// register the read word and the updated count, then write the store back or
// load the output register; no new item is accepted before the last is done.
// A filter result appears in the cycle after its last step; if the output
// register still holds an untaken result, the block waits in its last step.
// After reset and after each clear item the label store is zeroed one entry
// per cycle, all min(LABEL_COUNT, 65536) entries, while item_ready stays low.
// Sizes and size_limit are to be written over the APB port only while the block
// is idle; the user is bound to this, the block itself does not enforce it.
module segment_size_filter import ssf_pkg::*; #(
	parameter int LABEL_COUNT = 65536,
	parameter int COUNT_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        opcode,
	input  logic [LBL_W-1:0]  voxel_label,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [LBL_W-1:0]  filtered_label,
	output logic              last_voxel
);

	logic [POS_W-1:0]   last_x, last_y, last_z;
	logic [TOTAL_W-1:0] total;
	logic [LIMIT_W-1:0] size_limit;
	cmd_t               cmd;
	status_t            status;

	assign pready = 1'b1;

	ssf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.last_x     (last_x),
		.last_y     (last_y),
		.last_z     (last_z),
		.total      (total),
		.size_limit (size_limit)
	);

	ssf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	ssf_dp #(
		.LABEL_COUNT (LABEL_COUNT),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.voxel_label    (voxel_label),
		.last_x         (last_x),
		.last_y         (last_y),
		.last_z         (last_z),
		.total          (total),
		.size_limit     (size_limit),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.filtered_label (filtered_label),
		.last_voxel     (last_voxel)
	);

endmodule
